>>> sv/ttap_pkg.sv
// Shared types, codes and constants of the touch to absolute pointer block.
// No dependencies.
package ttap_pkg;

    localparam int unsigned ROLL_MARGIN_DEF = 50;
    localparam int unsigned POS_MAX         = 8191;

    localparam logic [4:0] TYPE_ABS = 5'd3;
    localparam logic [4:0] TYPE_KEY = 5'd1;

    localparam logic [9:0] CODE_X     = 10'd0;
    localparam logic [9:0] CODE_Y     = 10'd1;
    localparam logic [9:0] CODE_TRACK = 10'd57;
    localparam logic [9:0] CODE_DTAP  = 10'd333;
    localparam logic [9:0] CODE_LEFT  = 10'd272;
    localparam logic [9:0] CODE_RIGHT = 10'd273;

    localparam logic [1:0] ACT_MOVE    = 2'd0;
    localparam logic [1:0] ACT_PRESS   = 2'd1;
    localparam logic [1:0] ACT_RELEASE = 2'd2;
    localparam logic [1:0] ACT_AREA    = 2'd3;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_NEW  = 2'd1;
    localparam logic [1:0] MODE_CONT = 2'd2;
    localparam logic [1:0] MODE_TWO  = 2'd3;

    localparam logic [2:0] REG_PAD_MIN_X = 3'd0;
    localparam logic [2:0] REG_PAD_MAX_X = 3'd1;
    localparam logic [2:0] REG_PAD_MIN_Y = 3'd2;
    localparam logic [2:0] REG_PAD_MAX_Y = 3'd3;
    localparam logic [2:0] REG_SCREEN_W  = 3'd4;
    localparam logic [2:0] REG_SCREEN_H  = 3'd5;
    localparam logic [2:0] REG_AREA_W    = 3'd6;
    localparam logic [2:0] REG_AREA_H    = 3'd7;

    // Widths of the divider operands: dividend up to 17+1 bits times 14 bits.
    localparam int unsigned DIVD_W = 34;
    localparam int unsigned DIVS_W = 17;

    // Divider start and result.
    typedef struct packed {
        logic                     start;
        logic signed [DIVD_W-1:0] dividend;
        logic signed [DIVS_W:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [DIVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

>>> sv/ttap_div.sv
// Shared signed restoring divider, one quotient bit per cycle, truncating.
// Depends on ttap_pkg.
module ttap_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  ttap_pkg::div_req_t req,
    output ttap_pkg::div_rsp_t rsp
);

    localparam int unsigned W  = ttap_pkg::DIVD_W;
    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic          neg_reg, neg_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [W:0]    shifted;
    logic [W:0]    diff;
    logic [W-1:0]  abs_n;
    logic [W-1:0]  abs_d;

    // Magnitudes of the operands at start.
    always_comb
    begin
        abs_n = req.dividend[W-1] ? W'(-req.dividend) : W'(req.dividend);
        abs_d = req.divisor[ttap_pkg::DIVS_W] ?
                W'(-req.divisor) : W'(req.divisor);
    end

    // One shift and trial subtract per cycle.
    always_comb
    begin
        shifted   = {rem_reg[W-1:0], quo_reg[W-1]};
        diff      = shifted - {1'b0, dsr_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (req.start)
        begin
            quo_next  = abs_n;
            rem_next  = '0;
            dsr_next  = abs_d;
            neg_next  = req.dividend[W-1] ^ req.divisor[ttap_pkg::DIVS_W];
            busy_next = 1'b1;
            cnt_next  = CW'(W);
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_next = diff;
                quo_next = {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

>>> sv/touch_to_absolute_pointer_top.sv
// Top level: event decoding, touch state, sequencer around the shared divider.
// Depends on ttap_pkg and ttap_div.
// A pair runs two divisions, x then y; its first beat is valid once the second is done,
// and the next event is taken once the last beat is accepted (a pan gives one beat).
// Key and lift events: beat valid the next cycle, next event taken once it is accepted.
// Reset (rst_n, asynchronous): the state and configuration registers return to their reset values.
module touch_to_absolute_pointer_top
#(
    parameter int unsigned ROLL_MARGIN = ttap_pkg::ROLL_MARGIN_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // s_tdata: event_type[4:0], event_code[14:5], event_value[31:15]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // m_tdata: action[1:0], pointer_x[14:2], pointer_y[27:15], area_left[40:28],
    // area_top[53:41], zero fill above
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    output logic        m_tlast
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIVX  = 3'd1;
    localparam logic [2:0] ST_DIVY  = 3'd2;
    localparam logic [2:0] ST_OUT1  = 3'd3;
    localparam logic [2:0] ST_OUT2  = 3'd4;
    localparam logic [2:0] ST_WAITX = 3'd5;
    localparam logic [2:0] ST_WAITY = 3'd6;

    localparam int unsigned DW = ttap_pkg::DIVD_W;

    // Configuration registers.
    logic [15:0] pminx_reg, pmaxx_reg, pminy_reg, pmaxy_reg;
    logic [13:0] scrw_reg, scrh_reg, arw_reg, arh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pminx_reg <= 16'd0;
            pmaxx_reg <= 16'd4095;
            pminy_reg <= 16'd0;
            pmaxy_reg <= 16'd4095;
            scrw_reg  <= 14'd1920;
            scrh_reg  <= 14'd1080;
            arw_reg   <= 14'd1920;
            arh_reg   <= 14'd1080;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ttap_pkg::REG_PAD_MIN_X: pminx_reg <= cfg_data;
                ttap_pkg::REG_PAD_MAX_X: pmaxx_reg <= cfg_data;
                ttap_pkg::REG_PAD_MIN_Y: pminy_reg <= cfg_data;
                ttap_pkg::REG_PAD_MAX_Y: pmaxy_reg <= cfg_data;
                ttap_pkg::REG_SCREEN_W:  scrw_reg  <= cfg_data[13:0];
                ttap_pkg::REG_SCREEN_H:  scrh_reg  <= cfg_data[13:0];
                ttap_pkg::REG_AREA_W:    arw_reg   <= cfg_data[13:0];
                ttap_pkg::REG_AREA_H:    arh_reg   <= cfg_data[13:0];
                default:                 ;
            endcase
        end
    end

    // Touch state and sequencer.
    logic [2:0]         st_reg, st_next;
    logic [1:0]         mode_reg, mode_next;
    logic signed [16:0] px_reg, px_next, py_reg, py_next;
    logic signed [16:0] ax_reg, ax_next, ay_reg, ay_next;
    logic               pxv_reg, pxv_next, pyv_reg, pyv_next;
    logic [12:0]        arx_reg, arx_next, ary_reg, ary_next;
    logic               pan_reg, pan_next;
    logic signed [DW-1:0] qx_reg, qx_next;
    logic [1:0]         act1_reg, act1_next, act2_reg, act2_next;
    logic               two_reg, two_next;
    logic [12:0]        ptx_reg, ptx_next, pty_reg, pty_next;

    ttap_pkg::div_req_t dreq;
    ttap_pkg::div_rsp_t drsp;

    ttap_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    logic [4:0]         ev_type;
    logic [9:0]         ev_code;
    logic signed [16:0] ev_val;
    logic               lift;
    logic signed [17:0] spanx, spany;
    logic signed [17:0] relx, rely;

    assign ev_type = s_tdata[4:0];
    assign ev_code = s_tdata[14:5];
    assign ev_val  = s_tdata[31:15];
    assign lift    = (ev_code == ttap_pkg::CODE_TRACK) && (ev_val == -17'sd1);
    assign spanx   = $signed({2'b00, pmaxx_reg}) - $signed({2'b00, pminx_reg});
    assign spany   = $signed({2'b00, pmaxy_reg}) - $signed({2'b00, pminy_reg});
    assign s_tready = (st_reg == ST_IDLE);

    // Scaled pointer coordinate: clamp(org + q, 0, upper(scr)).
    function automatic logic [12:0] place(input logic signed [DW-1:0] q,
                                          input logic [12:0] org,
                                          input logic [13:0] scr);
        logic signed [DW+1:0] s;
        logic signed [DW+1:0] hi;
        begin
            s  = (DW+2)'(q) + $signed({{(DW-11){1'b0}}, org});
            hi = (scr == 14'd0) ? '0 :
                 ((scr > 14'd8192) ? (DW+2)'(8191) : $signed({{(DW-12){1'b0}}, scr}) - 1);
            if (s < 0)
                place = 13'd0;
            else if (s > hi)
                place = hi[12:0];
            else
                place = s[12:0];
        end
    endfunction

    // Area shift: clamp(pos + rel, 0, clamp(scr - sz, 0, 8191)).
    function automatic logic [12:0] shift(input logic [12:0] pos,
                                          input logic signed [DW-1:0] rel,
                                          input logic [13:0] scr,
                                          input logic [13:0] sz);
        logic signed [DW+1:0] s;
        logic signed [15:0]   lim;
        begin
            s   = (DW+2)'(rel) + $signed({{(DW-11){1'b0}}, pos});
            lim = $signed({2'b00, scr}) - $signed({2'b00, sz});
            if (lim < 0)
                lim = 16'sd0;
            else if (lim > 16'sd8191)
                lim = 16'sd8191;
            if (s < 0)
                shift = 13'd0;
            else if (s > (DW+2)'(lim))
                shift = lim[12:0];
            else
                shift = s[12:0];
        end
    endfunction

    logic signed [DW-1:0] roll;
    assign roll = $signed({{(DW-14){1'b0}}, arw_reg}) - DW'(ROLL_MARGIN);

    always_comb
    begin
        st_next   = st_reg;
        mode_next = mode_reg;
        px_next   = px_reg;
        py_next   = py_reg;
        ax_next   = ax_reg;
        ay_next   = ay_reg;
        pxv_next  = pxv_reg;
        pyv_next  = pyv_reg;
        arx_next  = arx_reg;
        ary_next  = ary_reg;
        pan_next  = pan_reg;
        qx_next   = qx_reg;
        act1_next = act1_reg;
        act2_next = act2_reg;
        two_next  = two_reg;
        ptx_next  = ptx_reg;
        pty_next  = pty_reg;
        relx      = $signed({px_reg[16], px_reg}) - $signed({ax_reg[16], ax_reg});
        rely      = $signed({py_reg[16], py_reg}) - $signed({ay_reg[16], ay_reg});
        dreq      = '0;

        unique case (st_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    // Decode one event and update the touch state.
                    two_next = 1'b0;
                    ptx_next = 13'd0;
                    pty_next = 13'd0;
                    if (ev_type == ttap_pkg::TYPE_ABS)
                    begin
                        priority if (mode_reg == ttap_pkg::MODE_NONE)
                        begin
                            if (ev_code == ttap_pkg::CODE_TRACK && !lift)
                                mode_next = ttap_pkg::MODE_NEW;
                        end
                        else
                        begin
                            pxv_next = pxv_reg;
                            pyv_next = pyv_reg;
                            if (mode_reg == ttap_pkg::MODE_CONT && lift)
                            begin
                                pxv_next  = 1'b0;
                                pyv_next  = 1'b0;
                                mode_next = ttap_pkg::MODE_NONE;
                                act1_next = ttap_pkg::ACT_RELEASE;
                                st_next   = ST_OUT2;
                            end
                            else if (ev_code == ttap_pkg::CODE_X)
                            begin
                                px_next  = ev_val;
                                pxv_next = 1'b1;
                                if (mode_reg == ttap_pkg::MODE_NEW)
                                    ax_next = ev_val;
                            end
                            else if (ev_code == ttap_pkg::CODE_Y)
                            begin
                                py_next  = ev_val;
                                pyv_next = 1'b1;
                                if (mode_reg == ttap_pkg::MODE_NEW)
                                    ay_next = ev_val;
                            end
                            if (mode_reg == ttap_pkg::MODE_TWO && lift)
                                mode_next = ttap_pkg::MODE_NONE;
                            if (pxv_next && pyv_next)
                            begin
                                pan_next = (mode_reg == ttap_pkg::MODE_TWO);
                                if (mode_reg == ttap_pkg::MODE_NEW)
                                    mode_next = ttap_pkg::MODE_CONT;
                                st_next = ST_DIVX;
                            end
                        end
                    end
                    else if (ev_type == ttap_pkg::TYPE_KEY && ev_val == 17'sd1)
                    begin
                        if (ev_code == ttap_pkg::CODE_DTAP)
                        begin
                            act1_next = ttap_pkg::ACT_RELEASE;
                            mode_next = ttap_pkg::MODE_TWO;
                            st_next   = ST_OUT2;
                        end
                        else if (ev_code == ttap_pkg::CODE_LEFT ||
                                 ev_code == ttap_pkg::CODE_RIGHT)
                        begin
                            arx_next = shift(arx_reg,
                                             (ev_code == ttap_pkg::CODE_LEFT) ? -roll : roll,
                                             scrw_reg, arw_reg);
                            act1_next = ttap_pkg::ACT_AREA;
                            st_next   = ST_OUT2;
                        end
                    end
                end
            end
            ST_DIVX:
            begin
                // Start x division: offset or pan step.
                dreq.start   = 1'b1;
                dreq.divisor = spanx;
                if (pan_reg)
                    dreq.dividend = DW'(relx) * $signed({{(DW-14){1'b0}}, scrw_reg});
                else
                    dreq.dividend = ($signed({{(DW-17){px_reg[16]}}, px_reg}) -
                                     $signed({{(DW-16){1'b0}}, pminx_reg})) *
                                    $signed({{(DW-14){1'b0}}, arw_reg});
                st_next = ST_WAITX;
            end
            ST_WAITX:
            begin
                if (drsp.done)
                begin
                    qx_next = (spanx == 18'sd0) ? '0 : drsp.quotient;
                    dreq.start   = 1'b1;
                    dreq.divisor = spany;
                    if (pan_reg)
                        dreq.dividend = DW'(rely) * $signed({{(DW-14){1'b0}}, scrh_reg});
                    else
                        dreq.dividend = ($signed({{(DW-17){py_reg[16]}}, py_reg}) -
                                         $signed({{(DW-16){1'b0}}, pminy_reg})) *
                                        $signed({{(DW-14){1'b0}}, arh_reg});
                    st_next = ST_WAITY;
                end
            end
            ST_WAITY:
            begin
                if (drsp.done)
                begin
                    st_next  = ST_DIVY;
                    qx_next  = qx_reg;
                    pxv_next = 1'b0;
                    pyv_next = 1'b0;
                    if (pan_reg)
                    begin
                        arx_next  = shift(arx_reg, qx_reg, scrw_reg, arw_reg);
                        ary_next  = shift(ary_reg,
                                          (spany == 18'sd0) ? '0 : drsp.quotient,
                                          scrh_reg, arh_reg);
                        ax_next   = px_reg;
                        ay_next   = py_reg;
                        act1_next = ttap_pkg::ACT_AREA;
                        st_next   = ST_OUT2;
                    end
                    else
                    begin
                        ptx_next  = place(qx_reg, arx_reg, scrw_reg);
                        pty_next  = place((spany == 18'sd0) ? '0 : drsp.quotient,
                                          ary_reg, scrh_reg);
                        act1_next = ttap_pkg::ACT_MOVE;
                        act2_next = ttap_pkg::ACT_PRESS;
                        two_next  = 1'b1;
                        st_next   = ST_OUT1;
                    end
                end
            end
            ST_OUT1:
            begin
                // First of two beats: pointer move.
                if (m_tready)
                begin
                    act1_next = act2_reg;
                    ptx_next  = 13'd0;
                    pty_next  = 13'd0;
                    two_next  = 1'b0;
                    st_next   = ST_OUT2;
                end
            end
            ST_OUT2:
            begin
                if (m_tready)
                    st_next = ST_IDLE;
            end
            ST_DIVY:
            begin
                st_next = ST_IDLE;
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            mode_reg <= ttap_pkg::MODE_NONE;
            px_reg   <= '0;
            py_reg   <= '0;
            ax_reg   <= '0;
            ay_reg   <= '0;
            pxv_reg  <= 1'b0;
            pyv_reg  <= 1'b0;
            arx_reg  <= '0;
            ary_reg  <= '0;
            pan_reg  <= 1'b0;
            two_reg  <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            mode_reg <= mode_next;
            px_reg   <= px_next;
            py_reg   <= py_next;
            ax_reg   <= ax_next;
            ay_reg   <= ay_next;
            pxv_reg  <= pxv_next;
            pyv_reg  <= pyv_next;
            arx_reg  <= arx_next;
            ary_reg  <= ary_next;
            pan_reg  <= pan_next;
            two_reg  <= two_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qx_reg   <= qx_next;
        act1_reg <= act1_next;
        act2_reg <= act2_next;
        ptx_reg  <= ptx_next;
        pty_reg  <= pty_next;
    end

    // Result beat.
    assign m_tvalid = (st_reg == ST_OUT1) || (st_reg == ST_OUT2);
    assign m_tlast  = (st_reg == ST_OUT2) && !two_reg;
    assign m_tdata  = {2'b00, ary_reg, arx_reg, pty_reg, ptx_reg, act1_reg};

endmodule

>>> tb/sv/touch_to_absolute_pointer_top_tb.sv
// Testbench of the touch to absolute pointer block: touch events in, pointer beats checked.
// Depends on ttap_pkg and touch_to_absolute_pointer_top.
module touch_to_absolute_pointer_top_tb;

    typedef struct packed {
        logic [1:0]  action;
        logic [12:0] px;
        logic [12:0] py;
        logic [12:0] left;
        logic [12:0] top;
        logic        last;
    } ptr_beat_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        m_tlast;

    touch_to_absolute_pointer_top dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // Predictor copy of configuration and touch state.
    longint pmin_x, pmax_x, pmin_y, pmax_y, scr_w, scr_h, ar_w, ar_h;
    logic [1:0] mode;
    longint pend_x, pend_y, anc_x, anc_y, org_x, org_y;
    bit     pend_xv, pend_yv;

    logic [31:0] event_queue[$];
    ptr_beat_t   beat_expect[$];
    int errors = 0;
    int beats_seen = 0;
    int events_sent = 0;
    bit idle_on = 1;
    bit s_taken = 0;
    int hold_off = 0;
    int s_gap = 0;
    int m_gap = 0;

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("[touch_to_absolute_pointer_top] ERROR");
        $finish;
    end

    function automatic longint clampv(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint screen_hi(longint scr);
        return clampv(scr - 1, 0, ttap_pkg::POS_MAX);
    endfunction

    function automatic longint scale_pos(longint p, longint lo, longint hi, longint org,
                                         longint sz, longint scr);
        longint span;
        longint off;
        span = hi - lo;
        off = (span != 0) ? ((p - lo) * sz) / span : 0;
        return clampv(org + off, 0, screen_hi(scr));
    endfunction

    function automatic longint shift_org(longint pos, longint rel, longint scr, longint sz);
        return clampv(pos + rel, 0, clampv(scr - sz, 0, ttap_pkg::POS_MAX));
    endfunction

    function automatic longint pan_delta(longint rel, longint scr, longint lo, longint hi);
        longint span;
        span = hi - lo;
        return (span != 0) ? (scr * rel) / span : 0;
    endfunction

    function automatic void push_beat(logic [1:0] act, longint px, longint py);
        ptr_beat_t b;
        b.action = act;
        b.px = px[12:0];
        b.py = py[12:0];
        b.left = org_x[12:0];
        b.top = org_y[12:0];
        b.last = 0;
        beat_expect.push_back(b);
    endfunction

    function automatic void emit_pair();
        longint px;
        longint py;
        px = scale_pos(pend_x, pmin_x, pmax_x, org_x, ar_w, scr_w);
        py = scale_pos(pend_y, pmin_y, pmax_y, org_y, ar_h, scr_h);
        push_beat(ttap_pkg::ACT_MOVE, px, py);
        push_beat(ttap_pkg::ACT_PRESS, 0, 0);
        pend_xv = 0;
        pend_yv = 0;
    endfunction

    // Work out the beats one event causes and update the predicted state.
    function automatic void predict_event(logic [31:0] ev);
        logic [4:0] etype;
        logic [9:0] ecode;
        longint     val;
        bit         lift;
        int         prev_count;
        etype = ev[4:0];
        ecode = ev[14:5];
        val = longint'($signed(ev[31:15]));
        lift = (ecode == ttap_pkg::CODE_TRACK) && (val == -1);
        prev_count = beat_expect.size();
        if (etype == ttap_pkg::TYPE_ABS)
        begin
            case (mode)
                ttap_pkg::MODE_NONE:
                    if (ecode == ttap_pkg::CODE_TRACK && val != -1) mode = ttap_pkg::MODE_NEW;
                ttap_pkg::MODE_NEW:
                begin
                    if (ecode == ttap_pkg::CODE_X)
                    begin
                        anc_x = val; pend_x = val; pend_xv = 1;
                    end
                    else if (ecode == ttap_pkg::CODE_Y)
                    begin
                        anc_y = val; pend_y = val; pend_yv = 1;
                    end
                    if (pend_xv && pend_yv)
                    begin
                        emit_pair();
                        mode = ttap_pkg::MODE_CONT;
                    end
                end
                ttap_pkg::MODE_CONT:
                begin
                    if (lift)
                    begin
                        push_beat(ttap_pkg::ACT_RELEASE, 0, 0);
                        pend_xv = 0; pend_yv = 0;
                        mode = ttap_pkg::MODE_NONE;
                    end
                    else if (ecode == ttap_pkg::CODE_X)
                    begin
                        pend_x = val; pend_xv = 1;
                    end
                    else if (ecode == ttap_pkg::CODE_Y)
                    begin
                        pend_y = val; pend_yv = 1;
                    end
                    if (pend_xv && pend_yv) emit_pair();
                end
                default:
                begin
                    if (ecode == ttap_pkg::CODE_X)
                    begin
                        pend_x = val; pend_xv = 1;
                    end
                    else if (ecode == ttap_pkg::CODE_Y)
                    begin
                        pend_y = val; pend_yv = 1;
                    end
                    if (pend_xv && pend_yv)
                    begin
                        org_x = shift_org(org_x, pan_delta(pend_x - anc_x, scr_w, pmin_x, pmax_x),
                                          scr_w, ar_w);
                        org_y = shift_org(org_y, pan_delta(pend_y - anc_y, scr_h, pmin_y, pmax_y),
                                          scr_h, ar_h);
                        anc_x = pend_x; anc_y = pend_y;
                        pend_xv = 0; pend_yv = 0;
                        push_beat(ttap_pkg::ACT_AREA, 0, 0);
                    end
                    if (lift) mode = ttap_pkg::MODE_NONE;
                end
            endcase
        end
        else if (etype == ttap_pkg::TYPE_KEY && val == 1)
        begin
            if (ecode == ttap_pkg::CODE_DTAP)
            begin
                push_beat(ttap_pkg::ACT_RELEASE, 0, 0);
                mode = ttap_pkg::MODE_TWO;
            end
            else if (ecode == ttap_pkg::CODE_LEFT || ecode == ttap_pkg::CODE_RIGHT)
            begin
                longint step;
                step = ar_w - longint'(ttap_pkg::ROLL_MARGIN_DEF);
                if (ecode == ttap_pkg::CODE_LEFT) step = -step;
                org_x = shift_org(org_x, step, scr_w, ar_w);
                push_beat(ttap_pkg::ACT_AREA, 0, 0);
            end
        end
        if (beat_expect.size() > prev_count) beat_expect[beat_expect.size() - 1].last = 1;
    endfunction

    function automatic logic [31:0] make_event(logic [4:0] t, logic [9:0] c, logic [16:0] v);
        return {v, c, t};
    endfunction

    function automatic logic [16:0] rand_pos(longint lo, longint hi);
        longint a;
        longint b;
        a = (lo < hi) ? lo : hi;
        b = (lo < hi) ? hi : lo;
        if ($urandom_range(0, 9) == 0) return 17'($urandom);
        return 17'($urandom_range(int'(a), int'(b + 20)) - 10);
    endfunction

    // Input acceptance is recorded at the rising edge.
    always @(posedge clk)
    begin
        s_taken <= rst_n && s_tvalid && s_tready;
    end

    // Driver: one beat offered at a time, random gaps, inputs move at the falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_taken)
            begin
                predict_event(s_tdata);
                events_sent++;
                if (idle_on && $urandom_range(0, 5) == 0) s_gap = $urandom_range(1, 5);
            end
            if (!s_tvalid || s_taken)
            begin
                if (s_gap > 0)
                begin
                    s_gap--;
                    s_tvalid <= 0;
                end
                else if (event_queue.size() > 0)
                begin
                    s_tdata <= event_queue.pop_front();
                    s_tvalid <= 1;
                end
                else
                    s_tvalid <= 0;
            end
        end
    end

    // Receiver: random idling and a long hold-off counted here in cycles.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_off > 0)
            begin
                hold_off--;
                m_tready <= 0;
            end
            else if (m_gap > 0)
            begin
                m_gap--;
                m_tready <= 0;
            end
            else
            begin
                if (idle_on && $urandom_range(0, 6) == 0) m_gap = $urandom_range(1, 5);
                m_tready <= 1;
            end
        end
    end

    // Monitor: compare each accepted output beat with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            ptr_beat_t got;
            got.action = m_tdata[1:0];
            got.px = m_tdata[14:2];
            got.py = m_tdata[27:15];
            got.left = m_tdata[40:28];
            got.top = m_tdata[53:41];
            got.last = m_tlast;
            beats_seen++;
            if (beat_expect.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat %h last %b", $time, m_tdata, m_tlast);
            end
            else
            begin
                ptr_beat_t want;
                want = beat_expect.pop_front();
                if (got !== want || m_tdata[55:54] !== 2'b00)
                begin
                    errors++;
                    $display("%0t: expected act %0d x %0d y %0d l %0d t %0d last %b",
                             $time, want.action, want.px, want.py, want.left, want.top,
                             want.last);
                    $display("%0t: actual   act %0d x %0d y %0d l %0d t %0d last %b",
                             $time, got.action, got.px, got.py, got.left, got.top, got.last);
                end
            end
        end
    end

    task automatic wait_drained();
        while (event_queue.size() > 0 || s_tvalid || beat_expect.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
        case (idx)
            ttap_pkg::REG_PAD_MIN_X: pmin_x = val;
            ttap_pkg::REG_PAD_MAX_X: pmax_x = val;
            ttap_pkg::REG_PAD_MIN_Y: pmin_y = val;
            ttap_pkg::REG_PAD_MAX_Y: pmax_y = val;
            ttap_pkg::REG_SCREEN_W:  scr_w = val[13:0];
            ttap_pkg::REG_SCREEN_H:  scr_h = val[13:0];
            ttap_pkg::REG_AREA_W:    ar_w = val[13:0];
            default:                 ar_h = val[13:0];
        endcase
    endtask

    task automatic set_config(int sel);
        case (sel)
            0:
            begin
                write_reg(ttap_pkg::REG_PAD_MIN_X, 0);     write_reg(ttap_pkg::REG_PAD_MAX_X, 4095);
                write_reg(ttap_pkg::REG_PAD_MIN_Y, 0);     write_reg(ttap_pkg::REG_PAD_MAX_Y, 4095);
                write_reg(ttap_pkg::REG_SCREEN_W, 1920);   write_reg(ttap_pkg::REG_SCREEN_H, 1080);
                write_reg(ttap_pkg::REG_AREA_W, 960);      write_reg(ttap_pkg::REG_AREA_H, 540);
            end
            1:
            begin
                write_reg(ttap_pkg::REG_PAD_MIN_X, 65535); write_reg(ttap_pkg::REG_PAD_MAX_X, 0);
                write_reg(ttap_pkg::REG_PAD_MIN_Y, 100);   write_reg(ttap_pkg::REG_PAD_MAX_Y, 100);
                write_reg(ttap_pkg::REG_SCREEN_W, 8192);   write_reg(ttap_pkg::REG_SCREEN_H, 8192);
                write_reg(ttap_pkg::REG_AREA_W, 1);        write_reg(ttap_pkg::REG_AREA_H, 8192);
            end
            2:
            begin
                write_reg(ttap_pkg::REG_PAD_MIN_X, 0);     write_reg(ttap_pkg::REG_PAD_MAX_X, 65535);
                write_reg(ttap_pkg::REG_PAD_MIN_Y, 65535); write_reg(ttap_pkg::REG_PAD_MAX_Y, 0);
                write_reg(ttap_pkg::REG_SCREEN_W, 1);      write_reg(ttap_pkg::REG_SCREEN_H, 1);
                write_reg(ttap_pkg::REG_AREA_W, 8192);     write_reg(ttap_pkg::REG_AREA_H, 1);
            end
            default:
            begin
                write_reg(ttap_pkg::REG_PAD_MIN_X, 16'($urandom_range(0, 2000)));
                write_reg(ttap_pkg::REG_PAD_MAX_X, 16'($urandom_range(1000, 65535)));
                write_reg(ttap_pkg::REG_PAD_MIN_Y, 16'($urandom_range(0, 2000)));
                write_reg(ttap_pkg::REG_PAD_MAX_Y, 16'($urandom_range(1000, 65535)));
                write_reg(ttap_pkg::REG_SCREEN_W, 16'($urandom_range(1, 8192)));
                write_reg(ttap_pkg::REG_SCREEN_H, 16'($urandom_range(1, 8192)));
                write_reg(ttap_pkg::REG_AREA_W, 16'($urandom_range(1, 8192)));
                write_reg(ttap_pkg::REG_AREA_H, 16'($urandom_range(1, 8192)));
            end
        endcase
    endtask

    // One touch: contact, one to four pairs, maybe a roll key and a stray x, then a lift; sometimes a two-finger pan.
    task automatic queue_gesture();
        int n;
        n = $urandom_range(1, 4);
        if ($urandom_range(0, 3) == 0)
        begin
            event_queue.push_back(make_event(ttap_pkg::TYPE_KEY, ttap_pkg::CODE_DTAP, 17'd1));
            for (int i = 0; i < n; i++)
            begin
                event_queue.push_back(make_event(ttap_pkg::TYPE_ABS, ttap_pkg::CODE_X,
                                                 rand_pos(pmin_x, pmax_x)));
                event_queue.push_back(make_event(ttap_pkg::TYPE_ABS, ttap_pkg::CODE_Y,
                                                 rand_pos(pmin_y, pmax_y)));
            end
        end
        else
        begin
            event_queue.push_back(make_event(ttap_pkg::TYPE_ABS, ttap_pkg::CODE_TRACK,
                                             17'($urandom_range(0, 9999))));
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 1))
                begin
                    event_queue.push_back(make_event(ttap_pkg::TYPE_ABS, ttap_pkg::CODE_X,
                                                     rand_pos(pmin_x, pmax_x)));
                    event_queue.push_back(make_event(ttap_pkg::TYPE_ABS, ttap_pkg::CODE_Y,
                                                     rand_pos(pmin_y, pmax_y)));
                end
                else
                begin
                    event_queue.push_back(make_event(ttap_pkg::TYPE_ABS, ttap_pkg::CODE_Y,
                                                     rand_pos(pmin_y, pmax_y)));
                    event_queue.push_back(make_event(ttap_pkg::TYPE_ABS, ttap_pkg::CODE_X,
                                                     rand_pos(pmin_x, pmax_x)));
                end
            end
        end
        if ($urandom_range(0, 2) == 0)
            event_queue.push_back(make_event(ttap_pkg::TYPE_KEY,
                                             $urandom_range(0, 1) ? ttap_pkg::CODE_LEFT
                                                                  : ttap_pkg::CODE_RIGHT,
                                             17'd1));
        if ($urandom_range(0, 5) == 0)
            event_queue.push_back(make_event(ttap_pkg::TYPE_ABS, ttap_pkg::CODE_X,
                                             rand_pos(pmin_x, pmax_x)));
        event_queue.push_back(make_event(ttap_pkg::TYPE_ABS, ttap_pkg::CODE_TRACK, 17'h1FFFF));
    endtask

    // Noise: any type, code and value, mostly ignored.
    task automatic queue_noise();
        logic [9:0] c;
        case ($urandom_range(0, 6))
            0: c = ttap_pkg::CODE_X;
            1: c = ttap_pkg::CODE_Y;
            2: c = ttap_pkg::CODE_TRACK;
            3: c = ttap_pkg::CODE_DTAP;
            4: c = ttap_pkg::CODE_LEFT;
            5: c = ttap_pkg::CODE_RIGHT;
            default: c = 10'($urandom);
        endcase
        event_queue.push_back(make_event($urandom_range(0, 3) ? 5'($urandom_range(0, 3))
                                                              : 5'($urandom),
                                         c, $urandom_range(0, 1) ? 17'($urandom_range(0, 2))
                                                                 : 17'($urandom)));
    endtask

    initial
    begin
        rst_n = 0;
        cfg_we = 0;
        cfg_index = 0;
        cfg_data = 0;
        s_tvalid = 0;
        s_tdata = 0;
        m_tready = 0;
        pmin_x = 0; pmax_x = 4095; pmin_y = 0; pmax_y = 4095;
        scr_w = 1920; scr_h = 1080; ar_w = 1920; ar_h = 1080;
        mode = ttap_pkg::MODE_NONE;
        pend_x = 0; pend_y = 0; anc_x = 0; anc_y = 0; org_x = 0; org_y = 0;
        pend_xv = 0; pend_yv = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed: reset config, field extremes, keys, stale sample, double tap alone.
        event_queue.push_back(make_event(ttap_pkg::TYPE_KEY, ttap_pkg::CODE_DTAP, 17'd1));
        event_queue.push_back(make_event(ttap_pkg::TYPE_ABS, ttap_pkg::CODE_X, 17'h1FFFF));
        event_queue.push_back(make_event(ttap_pkg::TYPE_ABS, ttap_pkg::CODE_Y, 17'h10000));
        event_queue.push_back(make_event(ttap_pkg::TYPE_ABS, ttap_pkg::CODE_X, 17'h0FFFF));
        event_queue.push_back(make_event(ttap_pkg::TYPE_ABS, ttap_pkg::CODE_TRACK, 17'h1FFFF));
        event_queue.push_back(make_event(ttap_pkg::TYPE_ABS, ttap_pkg::CODE_TRACK, 17'd5));
        event_queue.push_back(make_event(ttap_pkg::TYPE_ABS, ttap_pkg::CODE_Y, 17'd0));
        event_queue.push_back(make_event(ttap_pkg::TYPE_ABS, ttap_pkg::CODE_X, 17'h0FFFF));
        event_queue.push_back(make_event(ttap_pkg::TYPE_ABS, ttap_pkg::CODE_Y, 17'h10000));
        event_queue.push_back(make_event(ttap_pkg::TYPE_ABS, ttap_pkg::CODE_TRACK, 17'h1FFFF));
        event_queue.push_back(make_event(ttap_pkg::TYPE_KEY, ttap_pkg::CODE_RIGHT, 17'd1));
        event_queue.push_back(make_event(ttap_pkg::TYPE_KEY, ttap_pkg::CODE_RIGHT, 17'd1));
        event_queue.push_back(make_event(ttap_pkg::TYPE_KEY, ttap_pkg::CODE_LEFT, 17'd1));
        event_queue.push_back(make_event(ttap_pkg::TYPE_KEY, ttap_pkg::CODE_LEFT, 17'd0));
        event_queue.push_back(make_event(5'h1F, 10'h3FF, 17'h1FFFF));
        event_queue.push_back(make_event(5'd0, ttap_pkg::CODE_X, 17'd1));
        wait_drained();

        // Random phases across several settings: a typical one, then extremes, then random ones.
        for (int ph = 0; ph < 8; ph++)
        begin
            set_config(ph);
            if (ph == 7) idle_on = 0;
            for (int g = 0; g < 35; g++)
                if ($urandom_range(0, 4) == 0) queue_noise();
                else queue_gesture();
            if (ph == 3)
            begin
                // Receiver holds off while the sender keeps offering events.
                @(posedge clk);
                hold_off = 400;
            end
            wait_drained();
        end

        $display("Sent %0d touch events over 9 phases and checked %0d pointer beats.",
                 events_sent, beats_seen);
        if (errors == 0)
            $display("[touch_to_absolute_pointer_top] OK");
        else
            $display("[touch_to_absolute_pointer_top] ERROR");
        $finish;
    end
endmodule
